// ===== hw/rtl/two_axis_damped_spring_wobble_top_macros.svh =====
`ifndef TWO_AXIS_DAMPED_SPRING_WOBBLE_TOP_MACROS_SVH
`define TWO_AXIS_DAMPED_SPRING_WOBBLE_TOP_MACROS_SVH

// Both macros expect clk and arst_n in the scope where they are used.

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/tadsw_pkg.sv =====
`timescale 1ns / 1ps

package tadsw_pkg;

	// Configuration port
	localparam int CFG_IDX_BITS = 2;
	localparam int PCT_BITS     = 7;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ENABLE,
		REG_STRENGTH,
		REG_BOUNCE,
		REG_SETTLE
	} cfg_reg_t;

	localparam logic [PCT_BITS-1:0] STRENGTH_RST = 7'd36;
	localparam logic [PCT_BITS-1:0] BOUNCE_RST   = 7'd58;
	localparam logic [PCT_BITS-1:0] SETTLE_RST   = 7'd68;

	typedef struct packed {
		logic                enable;
		logic [PCT_BITS-1:0] strength;
		logic [PCT_BITS-1:0] bounce;
		logic [PCT_BITS-1:0] settle;
	} cfg_t;

	// Request codes
	typedef enum logic [1:0] {
		REQ_TICK,
		REQ_BEGIN,
		REQ_END,
		REQ_OBS
	} req_t;

	// Coefficient formulas: (base + step * pct) / COEF_DEN, in Q.frac
	localparam longint GAIN_BASE   = 900;
	localparam longint GAIN_STEP   = 23;
	localparam longint SPRING_BASE = 1200;
	localparam longint SPRING_STEP = 19;
	localparam longint DAMP_BASE   = 7200;
	localparam longint DAMP_STEP   = 23;
	localparam longint COEF_DEN    = 10000;
	localparam longint VEL_LIMIT   = 28;
	localparam longint SETTLE_NUM  = 18;
	localparam longint SETTLE_DEN  = 100;

	// Elaboration-time only: rounded fixed-point coefficient
	function automatic longint coef_calc(input longint base, input longint step,
			input longint pct, input int frac);
		return (((base + step * pct) << frac) + (COEF_DEN / 2)) / COEF_DEN;
	endfunction

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_CLEAR,
		OP_BEGIN,
		OP_END,
		OP_STORE_LAST,
		OP_DIFF,
		OP_MUL_IMP,
		OP_IMPULSE,
		OP_MUL_SPRING,
		OP_VEL_SPRING,
		OP_MUL_DAMP,
		OP_VEL_DAMP,
		OP_OFF_UPD,
		OP_EMIT_FINAL,
		OP_EMIT_PLACE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   axis_y;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic enable;
		logic match;
		logic target_valid;
		logic alive;
		logic moving;
		logic have_last;
		logic settled;
		logic out_full;
	} sts_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_IMP_MUL,
		ST_IMP_ADD,
		ST_SPR_MUL,
		ST_SPR_ADD,
		ST_DMP_MUL,
		ST_DMP_ADD,
		ST_OFF_ADD,
		ST_FINISH
	} state_t;

endpackage

// ===== hw/rtl/tadsw_cfg.sv =====
`timescale 1ns / 1ps

module tadsw_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tadsw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tadsw_pkg::PCT_BITS-1:0]       cfg_data,
	output tadsw_pkg::cfg_t                      cfg
);

	tadsw_pkg::cfg_t cfg_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable   <= 1'b1;
			cfg_q.strength <= tadsw_pkg::STRENGTH_RST;
			cfg_q.bounce   <= tadsw_pkg::BOUNCE_RST;
			cfg_q.settle   <= tadsw_pkg::SETTLE_RST;
		end else if (cfg_valid) begin
			unique case (tadsw_pkg::cfg_reg_t'(cfg_index))
				tadsw_pkg::REG_ENABLE:   cfg_q.enable   <= cfg_data[0];
				tadsw_pkg::REG_STRENGTH: cfg_q.strength <= cfg_data;
				tadsw_pkg::REG_BOUNCE:   cfg_q.bounce   <= cfg_data;
				tadsw_pkg::REG_SETTLE:   cfg_q.settle   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/tadsw_ctrl.sv =====
`timescale 1ns / 1ps

module tadsw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tadsw_pkg::sts_t   sts,
	output tadsw_pkg::cmd_t   cmd
);

	tadsw_pkg::state_t state_q, state_d;
	logic              axis_q, axis_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tadsw_pkg::ST_IDLE;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d    = state_q;
		axis_d     = axis_q;
		cmd.op     = tadsw_pkg::OP_NONE;
		cmd.axis_y = axis_q;
		in_stall   = 1'b1;
		unique case (state_q)
			tadsw_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = tadsw_pkg::OP_LATCH;
					state_d = tadsw_pkg::ST_DECODE;
				end
			end
			tadsw_pkg::ST_DECODE: begin
				state_d = tadsw_pkg::ST_IDLE;
				axis_d  = 1'b0;
				case (sts.req)
					tadsw_pkg::REQ_BEGIN: begin
						if (sts.enable)
							cmd.op = tadsw_pkg::OP_BEGIN;
					end
					tadsw_pkg::REQ_END: begin
						cmd.op = tadsw_pkg::OP_END;
					end
					tadsw_pkg::REQ_OBS: begin
						if (sts.enable && sts.match && sts.moving) begin
							if (!sts.have_last) begin
								cmd.op = tadsw_pkg::OP_STORE_LAST;
							end else begin
								cmd.op  = tadsw_pkg::OP_DIFF;
								state_d = tadsw_pkg::ST_IMP_MUL;
							end
						end
					end
					tadsw_pkg::REQ_TICK: begin
						if (!sts.enable || !sts.target_valid || !sts.alive)
							cmd.op = tadsw_pkg::OP_CLEAR;
						else
							state_d = tadsw_pkg::ST_SPR_MUL;
					end
					default: ;
				endcase
			end
			// Observed position: impulse on x, then y
			tadsw_pkg::ST_IMP_MUL: begin
				cmd.op  = tadsw_pkg::OP_MUL_IMP;
				state_d = tadsw_pkg::ST_IMP_ADD;
			end
			tadsw_pkg::ST_IMP_ADD: begin
				cmd.op = tadsw_pkg::OP_IMPULSE;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = tadsw_pkg::ST_IMP_MUL;
				end else begin
					state_d = tadsw_pkg::ST_IDLE;
				end
			end
			// Tick: spring, damping, offset on x, then y
			tadsw_pkg::ST_SPR_MUL: begin
				cmd.op  = tadsw_pkg::OP_MUL_SPRING;
				state_d = tadsw_pkg::ST_SPR_ADD;
			end
			tadsw_pkg::ST_SPR_ADD: begin
				cmd.op  = tadsw_pkg::OP_VEL_SPRING;
				state_d = tadsw_pkg::ST_DMP_MUL;
			end
			tadsw_pkg::ST_DMP_MUL: begin
				cmd.op  = tadsw_pkg::OP_MUL_DAMP;
				state_d = tadsw_pkg::ST_DMP_ADD;
			end
			tadsw_pkg::ST_DMP_ADD: begin
				cmd.op  = tadsw_pkg::OP_VEL_DAMP;
				state_d = tadsw_pkg::ST_OFF_ADD;
			end
			tadsw_pkg::ST_OFF_ADD: begin
				cmd.op = tadsw_pkg::OP_OFF_UPD;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = tadsw_pkg::ST_SPR_MUL;
				end else begin
					state_d = tadsw_pkg::ST_FINISH;
				end
			end
			// Result: wait here while the output register is held
			tadsw_pkg::ST_FINISH: begin
				if (sts.settled) begin
					if (!sts.out_full) begin
						cmd.op  = tadsw_pkg::OP_EMIT_FINAL;
						state_d = tadsw_pkg::ST_IDLE;
					end
				end else if (sts.have_last) begin
					if (!sts.out_full) begin
						cmd.op  = tadsw_pkg::OP_EMIT_PLACE;
						state_d = tadsw_pkg::ST_IDLE;
					end
				end else begin
					state_d = tadsw_pkg::ST_IDLE;
				end
			end
			default: state_d = tadsw_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/tadsw_dp.sv =====
`timescale 1ns / 1ps

module tadsw_dp #(
	parameter int FRAC_BITS = 12,
	parameter int POS_BITS  = 16,
	parameter int ID_BITS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tadsw_pkg::cfg_t             cfg,
	input  tadsw_pkg::cmd_t             cmd,
	output tadsw_pkg::sts_t             sts,
	input  logic [1:0]                  req_type,
	input  logic [ID_BITS-1:0]          window_id,
	input  logic                        window_alive,
	input  logic signed [POS_BITS-1:0]  pos_x,
	input  logic signed [POS_BITS-1:0]  pos_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ID_BITS-1:0]          target_id,
	output logic signed [POS_BITS-1:0]  place_x,
	output logic signed [POS_BITS-1:0]  place_y,
	output logic                        is_final
);

	localparam int VAL_BITS = FRAC_BITS + 12;
	localparam int CW       = FRAC_BITS + 1;
	localparam int MW       = (VAL_BITS > POS_BITS + 1) ? VAL_BITS : POS_BITS + 1;
	localparam int PW       = MW + CW + 1;
	localparam int XW       = PW + 2;
	localparam int NPCT     = 2 ** tadsw_pkg::PCT_BITS;

	localparam logic signed [XW-1:0] HALF = XW'(longint'(1) << (FRAC_BITS - 1));
	localparam logic signed [XW-1:0] VHI  = XW'((longint'(1) << (VAL_BITS - 1)) - 1);
	localparam logic signed [XW-1:0] VLO  = XW'(-(longint'(1) << (VAL_BITS - 1)));
	localparam logic signed [XW-1:0] PHI  = XW'((longint'(1) << (POS_BITS - 1)) - 1);
	localparam logic signed [XW-1:0] PLO  = XW'(-(longint'(1) << (POS_BITS - 1)));
	localparam logic signed [XW-1:0] LIM  = XW'(tadsw_pkg::VEL_LIMIT << FRAC_BITS);
	localparam logic signed [XW-1:0] NLIM = XW'(-(tadsw_pkg::VEL_LIMIT << FRAC_BITS));
	localparam logic signed [VAL_BITS-1:0] THR = VAL_BITS'(((tadsw_pkg::SETTLE_NUM
		<< FRAC_BITS) + tadsw_pkg::SETTLE_DEN / 2) / tadsw_pkg::SETTLE_DEN);
	localparam logic signed [VAL_BITS-1:0] NTHR = VAL_BITS'(-(((tadsw_pkg::SETTLE_NUM
		<< FRAC_BITS) + tadsw_pkg::SETTLE_DEN / 2) / tadsw_pkg::SETTLE_DEN));

	// Round to nearest, ties away from zero, dropping FRAC_BITS
	function automatic logic signed [XW-1:0] rescale(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] t;
		t = v + HALF - $signed(XW'(v[XW-1]));
		return t >>> FRAC_BITS;
	endfunction

	function automatic logic signed [VAL_BITS-1:0] sat_val(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		if (v > VHI)
			r = VHI;
		else if (v < VLO)
			r = VLO;
		else
			r = v;
		return r[VAL_BITS-1:0];
	endfunction

	function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		if (v > PHI)
			r = PHI;
		else if (v < PLO)
			r = PLO;
		else
			r = v;
		return r[POS_BITS-1:0];
	endfunction

	function automatic logic signed [VAL_BITS-1:0] clamp_lim(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		if (v > LIM)
			r = LIM;
		else if (v < NLIM)
			r = NLIM;
		else
			r = v;
		return r[VAL_BITS-1:0];
	endfunction

	function automatic logic small_mag(input logic signed [VAL_BITS-1:0] v);
		return (v < THR) && (v > NTHR);
	endfunction

	// Latched input item
	tadsw_pkg::req_t             req_q;
	logic [ID_BITS-1:0]          id_q;
	logic                        alive_q;
	logic signed [POS_BITS-1:0]  px_q, py_q;

	// Effect state
	logic [ID_BITS-1:0]          target_q;
	logic                        target_valid_q, moving_q, have_last_q;
	logic signed [POS_BITS-1:0]  last_x_q, last_y_q;
	logic signed [VAL_BITS-1:0]  off_x_q, off_y_q, vel_x_q, vel_y_q;

	// Working registers
	logic signed [POS_BITS:0]    dx_q, dy_q;
	logic signed [PW-1:0]        prod_q;
	logic [CW-1:0]               gain_q, spring_q, damp_q;

	// Output register
	logic                        out_valid_q;
	logic [ID_BITS-1:0]          target_id_q;
	logic signed [POS_BITS-1:0]  place_x_q, place_y_q;
	logic                        is_final_q;

	logic [CW-1:0]               gain_tab   [NPCT];
	logic [CW-1:0]               spring_tab [NPCT];
	logic [CW-1:0]               damp_tab   [NPCT];

	logic signed [MW-1:0]        mul_a;
	logic signed [CW:0]          mul_b;
	logic signed [VAL_BITS-1:0]  off_sel, vel_sel;
	logic signed [XW-1:0]        prod_x, prod_rs;
	logic signed [VAL_BITS-1:0]  vel_imp, vel_spr, vel_dmp, off_new;
	logic signed [POS_BITS-1:0]  plc_x, plc_y;
	logic                        match;

	// Coefficient tables, one entry per percent setting
	for (genvar i = 0; i < NPCT; i++) begin : g_coef
		assign gain_tab[i]   = CW'(tadsw_pkg::coef_calc(tadsw_pkg::GAIN_BASE,
			tadsw_pkg::GAIN_STEP, i, FRAC_BITS));
		assign spring_tab[i] = CW'(tadsw_pkg::coef_calc(tadsw_pkg::SPRING_BASE,
			tadsw_pkg::SPRING_STEP, i, FRAC_BITS));
		assign damp_tab[i]   = CW'(tadsw_pkg::coef_calc(tadsw_pkg::DAMP_BASE,
			tadsw_pkg::DAMP_STEP, i, FRAC_BITS));
	end

	// Axis select
	assign off_sel = cmd.axis_y ? off_y_q : off_x_q;
	assign vel_sel = cmd.axis_y ? vel_y_q : vel_x_q;

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			tadsw_pkg::OP_MUL_IMP: begin
				mul_a = cmd.axis_y ? MW'(dy_q) : MW'(dx_q);
				mul_b = $signed({1'b0, gain_q});
			end
			tadsw_pkg::OP_MUL_SPRING: begin
				mul_a = MW'(off_sel);
				mul_b = $signed({1'b0, spring_q});
			end
			tadsw_pkg::OP_MUL_DAMP: begin
				mul_a = MW'(vel_sel);
				mul_b = $signed({1'b0, damp_q});
			end
			default: ;
		endcase
	end

	// Post-multiply updates
	assign prod_x  = XW'(prod_q);
	assign prod_rs = rescale(prod_x);
	assign vel_imp = clamp_lim(XW'(vel_sel) + prod_x);
	assign vel_spr = sat_val(XW'(vel_sel) - prod_rs);
	assign vel_dmp = sat_val(prod_rs);
	assign off_new = sat_val(XW'(off_sel) + XW'(vel_sel));

	// Placement: last position plus rounded offset
	assign plc_x = sat_pos(XW'(last_x_q) + rescale(XW'(off_x_q)));
	assign plc_y = sat_pos(XW'(last_y_q) + rescale(XW'(off_y_q)));

	assign match = target_valid_q && (id_q == target_q);

	// Status to the controller
	always_comb begin
		sts.req          = req_q;
		sts.enable       = cfg.enable;
		sts.match        = match;
		sts.target_valid = target_valid_q;
		sts.alive        = alive_q;
		sts.moving       = moving_q;
		sts.have_last    = have_last_q;
		sts.settled      = !moving_q && small_mag(off_x_q) && small_mag(off_y_q)
			&& small_mag(vel_x_q) && small_mag(vel_y_q);
		sts.out_full     = out_valid_q && out_stall;
	end

	// Working and payload registers
	always_ff @(posedge clk) begin
		gain_q   <= gain_tab[cfg.strength];
		spring_q <= spring_tab[cfg.bounce];
		damp_q   <= damp_tab[cfg.settle];
		unique case (cmd.op)
			tadsw_pkg::OP_LATCH: begin
				req_q   <= tadsw_pkg::req_t'(req_type);
				id_q    <= window_id;
				alive_q <= window_alive;
				px_q    <= pos_x;
				py_q    <= pos_y;
			end
			tadsw_pkg::OP_DIFF: begin
				dx_q <= (POS_BITS + 1)'(px_q) - (POS_BITS + 1)'(last_x_q);
				dy_q <= (POS_BITS + 1)'(py_q) - (POS_BITS + 1)'(last_y_q);
			end
			tadsw_pkg::OP_MUL_IMP, tadsw_pkg::OP_MUL_SPRING, tadsw_pkg::OP_MUL_DAMP: begin
				prod_q <= mul_a * mul_b;
			end
			tadsw_pkg::OP_EMIT_FINAL: begin
				target_id_q <= target_q;
				place_x_q   <= last_x_q;
				place_y_q   <= last_y_q;
				is_final_q  <= 1'b1;
			end
			tadsw_pkg::OP_EMIT_PLACE: begin
				target_id_q <= target_q;
				place_x_q   <= plc_x;
				place_y_q   <= plc_y;
				is_final_q  <= 1'b0;
			end
			default: ;
		endcase
	end

	// Effect state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q       <= '0;
			target_valid_q <= 1'b0;
			moving_q       <= 1'b0;
			have_last_q    <= 1'b0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			off_x_q        <= '0;
			off_y_q        <= '0;
			vel_x_q        <= '0;
			vel_y_q        <= '0;
		end else begin
			unique case (cmd.op)
				tadsw_pkg::OP_CLEAR, tadsw_pkg::OP_EMIT_FINAL: begin
					target_q       <= '0;
					target_valid_q <= 1'b0;
					moving_q       <= 1'b0;
					have_last_q    <= 1'b0;
					last_x_q       <= '0;
					last_y_q       <= '0;
					off_x_q        <= '0;
					off_y_q        <= '0;
					vel_x_q        <= '0;
					vel_y_q        <= '0;
				end
				tadsw_pkg::OP_BEGIN: begin
					target_q       <= id_q;
					target_valid_q <= 1'b1;
					moving_q       <= 1'b1;
					have_last_q    <= 1'b1;
					last_x_q       <= px_q;
					last_y_q       <= py_q;
					off_x_q        <= '0;
					off_y_q        <= '0;
					vel_x_q        <= '0;
					vel_y_q        <= '0;
				end
				tadsw_pkg::OP_END: begin
					if (match)
						moving_q <= 1'b0;
				end
				tadsw_pkg::OP_STORE_LAST: begin
					last_x_q    <= px_q;
					last_y_q    <= py_q;
					have_last_q <= 1'b1;
				end
				tadsw_pkg::OP_DIFF: begin
					last_x_q <= px_q;
					last_y_q <= py_q;
				end
				tadsw_pkg::OP_IMPULSE: begin
					if (cmd.axis_y)
						vel_y_q <= vel_imp;
					else
						vel_x_q <= vel_imp;
				end
				tadsw_pkg::OP_VEL_SPRING: begin
					if (cmd.axis_y)
						vel_y_q <= vel_spr;
					else
						vel_x_q <= vel_spr;
				end
				tadsw_pkg::OP_VEL_DAMP: begin
					if (cmd.axis_y)
						vel_y_q <= vel_dmp;
					else
						vel_x_q <= vel_dmp;
				end
				tadsw_pkg::OP_OFF_UPD: begin
					if (cmd.axis_y)
						off_y_q <= off_new;
					else
						off_x_q <= off_new;
				end
				default: ;
			endcase
		end
	end

	// Output valid: set on emit, dropped once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == tadsw_pkg::OP_EMIT_FINAL || cmd.op == tadsw_pkg::OP_EMIT_PLACE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign target_id = target_id_q;
	assign place_x   = place_x_q;
	assign place_y   = place_y_q;
	assign is_final  = is_final_q;

endmodule

// ===== hw/rtl/two_axis_damped_spring_wobble_top.sv =====
`timescale 1ns / 1ps
// Two-axis damped spring for window wobble, one event per input transaction.
// Input channel (in_valid / in_stall): req_type selects tick, move begin,
// move end or position observed; window_id, window_alive, pos_x, pos_y go with it.
// Output channel (out_valid / out_stall): target_id, place_x, place_y, is_final.
// A tick yields at most one output transaction; other events yield none.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_index 0 enable,
// 1 strength, 2 bounce, 3 settle percent; write only while the block is idle.
// Steps per item, set by the one shared multiplier stepped through each axis:
//   begin / end: latch and decode; observed position: two multiply-accumulates;
//   tick: spring multiply, damping multiply and offset add per axis,
//   then the result, which is registered as the output transaction.
// One item is worked at a time; in_stall is high while an item is in work.
// A finished result sits in the output register while the next item is taken;
// a tick that reaches its result while that register is still stalled waits.
// Reset clears all spring state and the output valid and restores the
// configuration defaults (enabled, 36 / 58 / 68 percent).

module two_axis_damped_spring_wobble_top #(
	parameter int FRAC_BITS = 12,
	parameter int POS_BITS  = 16,
	parameter int ID_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          req_type,
	input  logic [ID_BITS-1:0]                  window_id,
	input  logic                                window_alive,
	input  logic signed [POS_BITS-1:0]          pos_x,
	input  logic signed [POS_BITS-1:0]          pos_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ID_BITS-1:0]                  target_id,
	output logic signed [POS_BITS-1:0]          place_x,
	output logic signed [POS_BITS-1:0]          place_y,
	output logic                                is_final,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tadsw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tadsw_pkg::PCT_BITS-1:0]      cfg_data
);

	tadsw_pkg::cfg_t cfg;
	tadsw_pkg::cmd_t cmd;
	tadsw_pkg::sts_t sts;

	tadsw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tadsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tadsw_dp #(
		.FRAC_BITS (FRAC_BITS),
		.POS_BITS  (POS_BITS),
		.ID_BITS   (ID_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.window_id    (window_id),
		.window_alive (window_alive),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.target_id    (target_id),
		.place_x      (place_x),
		.place_y      (place_y),
		.is_final     (is_final)
	);

endmodule

// ===== hw/rtl/tadsw_chk.sv =====
`timescale 1ns / 1ps
`include "two_axis_damped_spring_wobble_top_macros.svh"

module tadsw_chk #(
	parameter int POS_BITS = 16,
	parameter int ID_BITS  = 16
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [ID_BITS-1:0]          target_id,
	input logic signed [POS_BITS-1:0]  place_x,
	input logic signed [POS_BITS-1:0]  place_y,
	input logic                        is_final
);

	// A stalled result stays offered
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// and does not change under the stall
	`ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(target_id) && $stable(place_x) && $stable(place_y) && $stable(is_final))

	// An accepted transaction leaves the block busy in the next cycle
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// A new result only comes out of a transaction in work
	`ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind two_axis_damped_spring_wobble_top tadsw_chk #(
	.POS_BITS (POS_BITS),
	.ID_BITS  (ID_BITS)
) u_tadsw_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.target_id (target_id),
	.place_x   (place_x),
	.place_y   (place_y),
	.is_final  (is_final)
);

// ===== bench/tb_two_axis_damped_spring_wobble_top.sv =====
`timescale 1ns / 1ps

module tb_two_axis_damped_spring_wobble_top;
	import tadsw_pkg::*;

	localparam int     FRAC_Q       = 12;
	localparam int     POS_W        = 16;
	localparam int     ID_W         = 16;
	localparam int     VAL_W        = FRAC_Q + 12;
	localparam longint GAIN_B       = 900;
	localparam longint GAIN_K       = 23;
	localparam longint SPR_B        = 1200;
	localparam longint SPR_K        = 19;
	localparam longint DMP_B        = 7200;
	localparam longint DMP_K        = 23;
	localparam longint VEL_CAP      = longint'(28) << FRAC_Q;
	localparam longint SETTLE_THR   = ((longint'(18) << FRAC_Q) + 50) / 100;
	localparam int     NUM_PHASES   = 10;
	localparam int     PHASE_ITEMS  = 200;
	localparam int     OFF_ITEMS    = 60;
	localparam int     TICK_CAP     = 40;
	localparam int     IDLE_SETTLE  = 30;
	localparam int     QUIET_LIMIT  = 3000;

	typedef struct {
		req_t                     kind;
		logic [ID_W-1:0]          id;
		logic                     alive;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
	} wobble_ev_t;

	typedef struct {
		logic [ID_W-1:0]          id;
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic                     fin;
	} placement_t;

	typedef enum {CHK_MODEL, CHK_NONE, CHK_PLACE} row_chk_t;

	typedef struct {
		wobble_ev_t ev;
		row_chk_t   chk;
		placement_t want;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    req_type;
	logic [ID_W-1:0]               window_id;
	logic                          window_alive;
	logic signed [POS_W-1:0]       pos_x;
	logic signed [POS_W-1:0]       pos_y;
	logic                          out_valid;
	logic                          out_stall;
	logic [ID_W-1:0]               target_id;
	logic signed [POS_W-1:0]       place_x;
	logic signed [POS_W-1:0]       place_y;
	logic                          is_final;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_IDX_BITS-1:0]       cfg_index;
	logic [PCT_BITS-1:0]           cfg_data;

	two_axis_damped_spring_wobble_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.window_id    (window_id),
		.window_alive (window_alive),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.target_id    (target_id),
		.place_x      (place_x),
		.place_y      (place_y),
		.is_final     (is_final),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Spring state mirror and configuration copy
	logic                en_q       = 1'b1;
	logic [PCT_BITS-1:0] strength_q = 7'd36;
	logic [PCT_BITS-1:0] bounce_q   = 7'd58;
	logic [PCT_BITS-1:0] settle_q   = 7'd68;
	logic [ID_W-1:0]     trk_id;
	logic                trk_valid, trk_moving, trk_have_last;
	longint              last_px, last_py, off_x, off_y, vel_x, vel_y;

	placement_t pending_places[$];
	stim_row_t  stim_rows[$];
	int         fail_count   = 0;
	int         quiet_cycles = 0;
	int         events_sent  = 0;
	bit         burst_mode   = 0;

	// Clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint sat_w(input longint v, input int bits);
		longint hi, lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// Drop FRAC_Q bits, round half away from zero
	function automatic longint round_frac(input longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (FRAC_Q - 1))) >> FRAC_Q;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint pct_coef(input longint base, input longint step,
			input logic [PCT_BITS-1:0] pct);
		return (((base + step * longint'(pct)) << FRAC_Q) + 5000) / 10000;
	endfunction

	function automatic longint mag_of(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint kick(input longint vel, input longint d, input longint g);
		longint v;
		v = vel + d * g;
		if (v > VEL_CAP) return VEL_CAP;
		if (v < -VEL_CAP) return -VEL_CAP;
		return v;
	endfunction

	// Semi-implicit Euler on one axis: spring, damping, then offset
	function automatic void spring_axis_step(inout longint off, inout longint vel,
			input longint k_spr, input longint k_dmp);
		longint v;
		v = sat_w(vel + round_frac(-off * k_spr), VAL_W);
		v = sat_w(round_frac(v * k_dmp), VAL_W);
		vel = v;
		off = sat_w(off + v, VAL_W);
	endfunction

	function automatic void clear_track();
		trk_id = '0;
		trk_valid = 1'b0;
		trk_moving = 1'b0;
		trk_have_last = 1'b0;
		last_px = 0;
		last_py = 0;
		off_x = 0;
		off_y = 0;
		vel_x = 0;
		vel_y = 0;
	endfunction

	// Advance the mirror by one event; returns 1 when a placement is due
	function automatic bit spring_predict(input wobble_ev_t e, output placement_t p);
		longint gain, k_spr, k_dmp, dx, dy;
		p.id = '0;
		p.x = '0;
		p.y = '0;
		p.fin = 1'b0;
		case (e.kind)
			REQ_BEGIN: begin
				if (en_q) begin
					clear_track();
					trk_id = e.id;
					trk_valid = 1'b1;
					trk_moving = 1'b1;
					trk_have_last = 1'b1;
					last_px = longint'(e.px);
					last_py = longint'(e.py);
				end
				return 0;
			end
			REQ_END: begin
				if (trk_valid && e.id == trk_id)
					trk_moving = 1'b0;
				return 0;
			end
			REQ_OBS: begin
				if (!en_q || !trk_valid || e.id != trk_id || !trk_moving)
					return 0;
				if (!trk_have_last) begin
					last_px = longint'(e.px);
					last_py = longint'(e.py);
					trk_have_last = 1'b1;
					return 0;
				end
				dx = longint'(e.px) - last_px;
				dy = longint'(e.py) - last_py;
				last_px = longint'(e.px);
				last_py = longint'(e.py);
				gain = pct_coef(GAIN_B, GAIN_K, strength_q);
				vel_x = kick(vel_x, dx, gain);
				vel_y = kick(vel_y, dy, gain);
				return 0;
			end
			default: begin
				if (!en_q || !trk_valid || !e.alive) begin
					clear_track();
					return 0;
				end
				k_spr = pct_coef(SPR_B, SPR_K, bounce_q);
				k_dmp = pct_coef(DMP_B, DMP_K, settle_q);
				spring_axis_step(off_x, vel_x, k_spr, k_dmp);
				spring_axis_step(off_y, vel_y, k_spr, k_dmp);
				// settled: rest position, final mark, state cleared
				if (!trk_moving && mag_of(off_x) < SETTLE_THR && mag_of(off_y) < SETTLE_THR
						&& mag_of(vel_x) < SETTLE_THR && mag_of(vel_y) < SETTLE_THR) begin
					p.id = trk_id;
					p.x = last_px;
					p.y = last_py;
					p.fin = 1'b1;
					clear_track();
					return 1;
				end
				if (!trk_have_last)
					return 0;
				p.id = trk_id;
				p.x = sat_w(last_px + round_frac(off_x), POS_W);
				p.y = sat_w(last_py + round_frac(off_y), POS_W);
				p.fin = 1'b0;
				return 1;
			end
		endcase
	endfunction

	function automatic wobble_ev_t mk_ev(input req_t k, input logic [ID_W-1:0] id,
			input logic alive, input int px, input int py);
		wobble_ev_t e;
		e.kind = k;
		e.id = id;
		e.alive = alive;
		e.px = px;
		e.py = py;
		return e;
	endfunction

	function automatic void add_row(input req_t k, input logic [ID_W-1:0] id,
			input logic alive, input int px, input int py, input row_chk_t chk,
			input logic [ID_W-1:0] wid, input int wx, input int wy, input logic wfin);
		stim_row_t r;
		r.ev = mk_ev(k, id, alive, px, py);
		r.chk = chk;
		r.want.id = wid;
		r.want.x = wx;
		r.want.y = wy;
		r.want.fin = wfin;
		stim_rows.push_back(r);
	endfunction

	function automatic int rand_full();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Mostly small moves, some large, a few anywhere
	function automatic int rand_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return int'($urandom_range(0, 40)) - 20;
		if (r < 95) return int'($urandom_range(0, 1000)) - 500;
		return rand_full();
	endfunction

	function automatic int next_gap();
		int r;
		if (burst_mode) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic wobble_ev_t noise_event(input logic [ID_W-1:0] gid);
		logic [ID_W-1:0] id;
		id = ($urandom_range(0, 1) == 0) ? gid : ID_W'($urandom);
		return mk_ev(req_t'($urandom_range(0, 3)), id, $urandom_range(0, 1),
			rand_full(), rand_full());
	endfunction

	// Input transaction: drive at falling edge, hold until taken
	task automatic send_event(input wobble_ev_t e, input int gap, output bit got,
			output placement_t p);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= e.kind;
		window_id <= e.id;
		window_alive <= e.alive;
		pos_x <= e.px;
		pos_y <= e.py;
		do @(posedge clk); while (in_stall !== 1'b0);
		got = spring_predict(e, p);
		events_sent++;
	endtask

	task automatic send_checked(input wobble_ev_t e);
		bit got;
		placement_t p;
		send_event(e, next_gap(), got, p);
		if (got)
			pending_places.push_back(p);
	endtask

	// Stop sending until every placement is back; optionally let the block go idle
	task automatic drain_results(input bit settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_places.size() != 0) @(posedge clk);
		if (settle)
			repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [PCT_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_ENABLE:   en_q = val[0];
			REG_STRENGTH: strength_q = val;
			REG_BOUNCE:   bounce_q = val;
			REG_SETTLE:   settle_q = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One drag: begin, observed moves with ticks between, end, ticks until at rest or TICK_CAP ticks
	task automatic run_gesture();
		logic [ID_W-1:0] gid;
		int cx, cy, n_obs, n_ticks;
		burst_mode = ($urandom_range(0, 4) == 0);
		gid = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			cx = rand_full();
			cy = rand_full();
		end else begin
			cx = int'($urandom_range(0, 2000)) - 1000;
			cy = int'($urandom_range(0, 2000)) - 1000;
		end
		send_checked(mk_ev(REQ_BEGIN, gid, $urandom_range(0, 1), cx, cy));
		n_obs = $urandom_range(1, 12);
		for (int i = 0; i < n_obs; i++) begin
			cx += rand_delta();
			cy += rand_delta();
			send_checked(mk_ev(REQ_OBS, gid, $urandom_range(0, 1), cx, cy));
			if ($urandom_range(0, 2) == 0)
				send_checked(mk_ev(REQ_TICK, $urandom, 1'b1, rand_full(), rand_full()));
			if ($urandom_range(0, 9) == 0)
				send_checked(noise_event(gid));
		end
		send_checked(mk_ev(REQ_END, ($urandom_range(0, 7) == 0) ? ID_W'($urandom) : gid,
			$urandom_range(0, 1), rand_full(), rand_full()));
		n_ticks = 0;
		while (trk_valid && n_ticks < TICK_CAP) begin
			send_checked(mk_ev(REQ_TICK, $urandom, $urandom_range(0, 60) != 0,
				rand_full(), rand_full()));
			n_ticks++;
		end
		if ($urandom_range(0, 29) == 0)
			drain_results(1'b0);
	endtask

	// Output transactions checked in order against the predicted placements
	always @(posedge clk) begin
		placement_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (out_valid && !out_stall) begin
				if (pending_places.size() == 0) begin
					$error("output transaction with none expected: target_id %0h", target_id);
					fail_count++;
				end else begin
					want = pending_places.pop_front();
					if (target_id !== want.id) begin
						$error("target_id: expected %0h, got %0h", want.id, target_id);
						fail_count++;
					end
					if (place_x !== want.x) begin
						$error("place_x: expected %0d, got %0d", want.x, place_x);
						fail_count++;
					end
					if (place_y !== want.y) begin
						$error("place_y: expected %0d, got %0d", want.y, place_y);
						fail_count++;
					end
					if (is_final !== want.fin) begin
						$error("is_final: expected %0b, got %0b", want.fin, is_final);
						fail_count++;
					end
				end
			end
		end
	end

	// Receiver back-pressure: free runs, short stalls, toggling, rare long holds
	initial begin
		int r, len;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				len = $urandom_range(1, 40);
				@(negedge clk);
				out_stall <= 1'b0;
				repeat (len - 1) @(negedge clk);
			end else if (r < 80) begin
				len = $urandom_range(1, 3);
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (len - 1) @(negedge clk);
			end else if (r < 97) begin
				@(negedge clk);
				out_stall <= ~out_stall;
			end else begin
				len = $urandom_range(20, 60);
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	// Watchdog on cycles with no transaction anywhere
	initial begin
		wait (arst_n === 1'b1);
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [PCT_BITS-1:0] ph_en[NUM_PHASES]  = '{1, 1, 1,   1,   0,  1, 1,   1, 1,   1};
		logic [PCT_BITS-1:0] ph_str[NUM_PHASES] = '{36, 0, 127, 100, 20, 0, 100, 0, 0,   36};
		logic [PCT_BITS-1:0] ph_bnc[NUM_PHASES] = '{58, 0, 127, 100, 90, 0, 0,   0, 127, 58};
		logic [PCT_BITS-1:0] ph_stl[NUM_PHASES] = '{68, 0, 127, 100, 40, 0, 127, 0, 0,   68};
		bit         got;
		placement_t p;
		int         phase_end;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_TICK;
		window_id = '0;
		window_alive = 1'b0;
		pos_x = '0;
		pos_y = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		clear_track();

		// two phases take random settings
		ph_str[5] = $urandom_range(0, 127);
		ph_bnc[5] = $urandom_range(0, 127);
		ph_stl[5] = $urandom_range(0, 127);
		ph_str[7] = $urandom_range(0, 127);
		ph_bnc[7] = $urandom_range(0, 127);
		ph_stl[7] = $urandom_range(0, 127);

		// Directed table, reset settings
		add_row(REQ_TICK,  16'h0000, 1, 0, 0, CHK_NONE, 0, 0, 0, 0);          // no target after reset
		add_row(REQ_OBS,   16'h0005, 1, 3, 4, CHK_MODEL, 0, 0, 0, 0);         // no target: ignored
		add_row(REQ_END,   16'h0005, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_BEGIN, 16'h0000, 0, -32768, 32767, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_TICK,  16'hFFFF, 1, 0, 0, CHK_PLACE, 16'h0000, -32768, 32767, 0);
		add_row(REQ_END,   16'h0000, 1, 0, 0, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_TICK,  16'h0000, 1, 0, 0, CHK_PLACE, 16'h0000, -32768, 32767, 1);
		add_row(REQ_TICK,  16'h0000, 1, 0, 0, CHK_NONE, 0, 0, 0, 0);          // state was cleared
		add_row(REQ_BEGIN, 16'hFFFF, 1, 32767, -32768, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_OBS,   16'h1234, 1, 0, 0, CHK_MODEL, 0, 0, 0, 0);         // other window
		add_row(REQ_OBS,   16'hFFFF, 1, -32768, 32767, CHK_MODEL, 0, 0, 0, 0);// velocity clamps
		add_row(REQ_TICK,  16'h0000, 1, 0, 0, CHK_MODEL, 0, 0, 0, 0);         // placement saturates
		add_row(REQ_TICK,  16'hFFFF, 0, 0, 0, CHK_NONE, 0, 0, 0, 0);          // window gone
		add_row(REQ_TICK,  16'hFFFF, 1, 0, 0, CHK_NONE, 0, 0, 0, 0);
		add_row(REQ_BEGIN, 16'h00A5, 1, 100, -50, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_OBS,   16'h00A5, 0, 103, -54, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_OBS,   16'h00A5, 1, 96, -40, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_END,   16'h00A6, 1, 0, 0, CHK_MODEL, 0, 0, 0, 0);         // wrong id: still moving
		add_row(REQ_TICK,  16'h00A5, 1, 0, 0, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_OBS,   16'h00A5, 1, 90, -30, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_END,   16'h00A5, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_OBS,   16'h00A5, 1, 0, 0, CHK_MODEL, 0, 0, 0, 0);         // not moving: ignored
		add_row(REQ_TICK,  16'h00A5, 1, 0, 0, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_TICK,  16'h00A5, 1, 0, 0, CHK_MODEL, 0, 0, 0, 0);
		add_row(REQ_BEGIN, 16'h5A5A, 1, 7, -7, CHK_MODEL, 0, 0, 0, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			send_event(stim_rows[i].ev, next_gap(), got, p);
			case (stim_rows[i].chk)
				CHK_MODEL: if (got) pending_places.push_back(p);
				CHK_PLACE: pending_places.push_back(stim_rows[i].want);
				default: ;
			endcase
		end

		// Random drags under a series of settings, written while idle
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_results(1'b1);
			write_reg(REG_ENABLE, ph_en[ph]);
			write_reg(REG_STRENGTH, ph_str[ph]);
			write_reg(REG_BOUNCE, ph_bnc[ph]);
			write_reg(REG_SETTLE, ph_stl[ph]);
			phase_end = events_sent + (ph_en[ph][0] ? PHASE_ITEMS : OFF_ITEMS);
			while (events_sent < phase_end)
				run_gesture();
		end

		drain_results(1'b1);
		if (fail_count == 0 && pending_places.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== two_axis_damped_spring_wobble_top.f =====
+incdir+hw/rtl
hw/rtl/tadsw_pkg.sv
hw/rtl/tadsw_cfg.sv
hw/rtl/tadsw_ctrl.sv
hw/rtl/tadsw_dp.sv
hw/rtl/two_axis_damped_spring_wobble_top.sv
hw/rtl/tadsw_chk.sv
bench/tb_two_axis_damped_spring_wobble_top.sv
